### rtl/l2pwm_pkg.sv
// ---------------------------------------------------------------------------
// l2pwm_pkg: shared constants, types and calibration table
// Widths, stage codes and the Q0.16 brightness calibration curve used by
// the level to PWM duty interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package l2pwm_pkg;

  // Level format: signed Q2.FracBits
  localparam int FracBits    = 16;
  localparam int LevelW      = FracBits + 2;
  // Calibration curve: TablePoints evenly spaced points in Q0.16
  localparam int TablePoints = 11;
  localparam int SegCount    = TablePoints - 1;
  localparam int IdxW        = $clog2(TablePoints);
  localparam int CalFracBits = 16;
  localparam int CalW        = CalFracBits + 1;
  // Segment position: fraction of the level times the segment count
  localparam int ScaledW     = FracBits + IdxW;
  // Blend lo*2^F + (hi-lo)*frac, exact in Q0.(16+F)
  localparam int DiffW       = CalW + 1;
  localparam int BlendW      = CalW + FracBits;
  localparam int ProdW       = BlendW + 2;
  localparam int OutShift    = CalFracBits + FracBits;
  // PWM resolution
  localparam int MaxPwmBits  = 16;
  localparam int FsW         = MaxPwmBits;
  localparam int DutyW       = 16;
  localparam int PwmBitsW    = 5;
  localparam logic [PwmBitsW-1:0] PwmBitsReset = 5'd10;

  // What the last stage does with an item
  typedef enum logic [1:0] {
    KIND_INTERP = 2'b00,
    KIND_ZERO   = 2'b01,
    KIND_FULL   = 2'b10
  } kind_e;

  // Calibration curve, fraction times 65536 rounded to nearest
  function automatic logic [CalW-1:0] cal_lut(input logic [IdxW-1:0] idx);
    logic [CalW-1:0] val;
    case (idx)
      4'd0:    val = 17'd7209;
      4'd1:    val = 17'd8520;
      4'd2:    val = 17'd10486;
      4'd3:    val = 17'd13107;
      4'd4:    val = 17'd17039;
      4'd5:    val = 17'd20972;
      4'd6:    val = 17'd28836;
      4'd7:    val = 17'd35389;
      4'd8:    val = 17'd42598;
      4'd9:    val = 17'd53740;
      4'd10:   val = 17'd65536;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### rtl/l2pwm_if.sv
// ---------------------------------------------------------------------------
// l2pwm_if: valid/ready channels of the interpolator
// Level channel (signed Q2.16 brightness) and duty channel (PWM compare).
// ---------------------------------------------------------------------------
`default_nettype none

interface l2pwm_level_if import l2pwm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [LevelW-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface l2pwm_duty_if import l2pwm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DutyW-1:0] duty;

  modport source (output valid, output duty, input ready);
  modport sink   (input valid, input duty, output ready);
endinterface

`default_nettype wire

### rtl/l2pwm_pipe.sv
// ---------------------------------------------------------------------------
// l2pwm_pipe: four-stage interpolation pipeline
// Classify and split level, look up segment, blend, scale to full scale.
// ---------------------------------------------------------------------------
`default_nettype none

module l2pwm_pipe import l2pwm_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [FsW-1:0] fs_i,
  l2pwm_level_if.sink         lvl_i,
  l2pwm_duty_if.source        duty_o
);

  // stage 1: class, segment index and fraction
  logic                s1_vld_q;
  kind_e               s1_kind_q, s1_kind_d;
  logic [IdxW-1:0]     s1_idx_q, s1_idx_d;
  logic [FracBits-1:0] s1_frac_q, s1_frac_d;
  // stage 2: segment end points
  logic                    s2_vld_q;
  kind_e                   s2_kind_q;
  logic [CalW-1:0]         s2_lo_q, s2_lo_d;
  logic signed [DiffW-1:0] s2_diff_q, s2_diff_d;
  logic [FracBits-1:0]     s2_frac_q;
  // stage 3: blend
  logic              s3_vld_q;
  kind_e             s3_kind_q;
  logic [BlendW-1:0] s3_blend_q, s3_blend_d;
  // stage 4: output register
  logic             out_vld_q;
  logic [DutyW-1:0] duty_q, duty_d;

  logic rdy1, rdy2, rdy3, rdy4;
  logic [ScaledW-1:0]      scaled;
  logic [CalW-1:0]         hi;
  logic signed [ProdW-1:0] blend_s;
  logic [BlendW+FsW-1:0]   num_fs;

  // a stage loads when empty or when its successor takes its item
  assign rdy4 = !out_vld_q || duty_o.ready;
  assign rdy3 = !s3_vld_q || rdy4;
  assign rdy2 = !s2_vld_q || rdy3;
  assign rdy1 = !s1_vld_q || rdy2;
  assign lvl_i.ready = rdy1;

  always_comb begin
    scaled    = ScaledW'(lvl_i.level[FracBits-1:0]) * ScaledW'(SegCount);
    s1_idx_d  = scaled[ScaledW-1:FracBits];
    s1_frac_d = scaled[FracBits-1:0];
    if (lvl_i.level[LevelW-1] || (lvl_i.level == '0)) begin
      s1_kind_d = KIND_ZERO;
    end else if (lvl_i.level[LevelW-2:FracBits] != '0) begin
      s1_kind_d = KIND_FULL;
    end else if (s1_idx_d >= IdxW'(SegCount)) begin
      s1_kind_d = KIND_FULL;
    end else begin
      s1_kind_d = KIND_INTERP;
    end
  end

  always_comb begin
    s2_lo_d   = cal_lut(s1_idx_q);
    hi        = cal_lut(s1_idx_q + IdxW'(1));
    s2_diff_d = $signed({1'b0, hi}) - $signed({1'b0, s2_lo_d});
  end

  always_comb begin
    blend_s = $signed({2'b00, s2_lo_q, {FracBits{1'b0}}})
            + s2_diff_q * $signed({1'b0, s2_frac_q});
    s3_blend_d = blend_s[ProdW-1] ? '0 : blend_s[BlendW-1:0];
  end

  always_comb begin
    num_fs = (BlendW+FsW)'(s3_blend_q) * (BlendW+FsW)'(fs_i);
    case (s3_kind_q)
      KIND_INTERP: duty_d = DutyW'(num_fs >> OutShift);
      KIND_ZERO:   duty_d = '0;
      KIND_FULL:   duty_d = DutyW'(fs_i);
      default:     duty_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rdy1) s1_vld_q  <= lvl_i.valid;
      if (rdy2) s2_vld_q  <= s1_vld_q;
      if (rdy3) s3_vld_q  <= s2_vld_q;
      if (rdy4) out_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && lvl_i.valid) begin
      s1_kind_q <= s1_kind_d;
      s1_idx_q  <= s1_idx_d;
      s1_frac_q <= s1_frac_d;
    end
    if (rdy2 && s1_vld_q) begin
      s2_kind_q <= s1_kind_q;
      s2_lo_q   <= s2_lo_d;
      s2_diff_q <= s2_diff_d;
      s2_frac_q <= s1_frac_q;
    end
    if (rdy3 && s2_vld_q) begin
      s3_kind_q  <= s2_kind_q;
      s3_blend_q <= s3_blend_d;
    end
    if (rdy4 && s3_vld_q) begin
      duty_q <= duty_d;
    end
  end

  assign duty_o.valid = out_vld_q;
  assign duty_o.duty  = duty_q;

  a_neg_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_i.valid && lvl_i.ready && lvl_i.level[LevelW-1] |=> s1_kind_q == KIND_ZERO)
    else $error("negative level not classed as zero");

  a_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q && rdy4 && (s3_kind_q == KIND_ZERO) |=> duty_q == '0)
    else $error("zero class gave nonzero duty");

  a_full_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q && rdy4 && (s3_kind_q == KIND_FULL) |=> duty_q == DutyW'($past(fs_i)))
    else $error("full class did not give full scale");

  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q && !rdy4 |=> s3_vld_q && $stable(s3_blend_q) && $stable(s3_kind_q))
    else $error("blend stage lost its item under stall");

endmodule

`default_nettype wire

### rtl/level_to_pwm_duty_interp_top.sv
// ---------------------------------------------------------------------------
// level_to_pwm_duty_interp_top: brightness level to PWM duty
// Calibrated piecewise linear mapping of a Q2.16 level to a PWM compare value.
// ---------------------------------------------------------------------------
// Usage:
//   lvl_i   : valid/ready sink carrying one signed Q2.16 level per item
//             (65536 is full brightness; the level is clamped to 0..1).
//   duty_o  : valid/ready source carrying one duty per level item, in order.
//   cfg_we_i/cfg_wdata_i : write pwm_bits, the PWM resolution (full scale
//             2^pwm_bits - 1, 0 acts as 1, above 16 acts as 16). Write it
//             only while no item is in flight.
// Pipeline: four register stages (classify, table lookup, blend multiply,
//   full-scale multiply); the first loads at the accepting edge.
// Throughput: one item per cycle while duty_o takes its items; every stage
//   is a register with its own valid bit, so a bubble anywhere lets the
//   input keep accepting items.
// Reset: all stages empty, pwm_bits = 10 (full scale 1023).
// Stall: when duty_o is not taken, hold the output item and let the
//   stages behind it fill; lvl_i.ready drops once all four are occupied.
//   Nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`default_nettype none

module level_to_pwm_duty_interp_top import l2pwm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [PwmBitsW-1:0] cfg_wdata_i,
  l2pwm_level_if.sink              lvl_i,
  l2pwm_duty_if.source             duty_o
);

  logic [PwmBitsW-1:0] pwm_bits_q, pwm_bits_d;
  logic [PwmBitsW-1:0] bits_eff;
  logic [FsW:0]        fs_wide;
  logic [FsW-1:0]      fs;

  // take a new resolution on write enable, hold otherwise
  assign pwm_bits_d = cfg_we_i ? cfg_wdata_i : pwm_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_bits_q <= PwmBitsReset;
    end else begin
      pwm_bits_q <= pwm_bits_d;
    end
  end

  // clamp the resolution to 1..MaxPwmBits and form the full scale
  always_comb begin
    bits_eff = pwm_bits_q;
    if (pwm_bits_q == '0) begin
      bits_eff = PwmBitsW'(1);
    end else if (pwm_bits_q > PwmBitsW'(MaxPwmBits)) begin
      bits_eff = PwmBitsW'(MaxPwmBits);
    end
    fs_wide = ((FsW+1)'(1) << bits_eff) - (FsW+1)'(1);
    fs      = fs_wide[FsW-1:0];
  end

  // interpolation datapath
  l2pwm_pipe u_pipe (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fs_i   (fs),
    .lvl_i  (lvl_i),
    .duty_o (duty_o)
  );

endmodule

`default_nettype wire

### test/level_to_pwm_duty_interp_top_tb.sv
// ---------------------------------------------------------------------------
// level_to_pwm_duty_interp_top_tb: self-checking bench for the duty mapper
// A driver feeds brightness levels from a queue, and a shadow of the
// calibration curve predicts each duty when the level item is accepted.
// A monitor compares every duty item in order with those predictions.
// Both handshake sides idle in random bursts. The PWM resolution steps
// through several settings, including both ends of its 5-bit range.
// ---------------------------------------------------------------------------
module level_to_pwm_duty_interp_top_tb;
  import l2pwm_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int RstCycles     = 4;
  localparam int PhaseCount    = 8;
  localparam int PhaseItems    = 96;
  localparam int HoldCycles    = 60;
  localparam int DrainCycles   = 12;
  localparam int TimeoutCycles = 200000;

  // Shadow copy of the calibration curve, Q0.16
  localparam int unsigned CalCurve [TablePoints] = '{
    7209, 8520, 10486, 13107, 17039, 20972, 28836, 35389, 42598, 53740, 65536
  };

  // PWM resolution for each phase after the directed run; both ends included
  localparam int unsigned WidthPlan [PhaseCount] = '{16, 1, 0, 31, 17, 5, 13, 16};

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [DutyW-1:0]  duty;
  } duty_exp_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [PwmBitsW-1:0] cfg_wdata_i;

  l2pwm_level_if lvl_ch ();
  l2pwm_duty_if  duty_ch ();

  level_to_pwm_duty_interp_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .lvl_i       (lvl_ch),
    .duty_o      (duty_ch)
  );

  logic [LevelW-1:0]   level_q [$];    // levels waiting to be offered
  duty_exp_t           duty_exp_q [$]; // predicted duties, oldest first
  logic [PwmBitsW-1:0] width_now;      // shadow of the pwm_bits register
  bit                  idle_on;        // random bursts allowed on both sides
  int                  n_mismatch;
  int                  hold_req;       // bumped by the sequencer
  int                  hold_ack;       // bumped by the monitor when it starts a hold
  int                  hold_cnt;
  int                  src_gap;
  int                  sink_gap;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Map a level to its duty: clamp to 0..1, pick a segment from the top bits
  // of level*10, blend its end points exactly, scale by full scale, truncate.
  function automatic logic [DutyW-1:0] duty_for_level(input logic [LevelW-1:0] lvl,
                                                       input logic [PwmBitsW-1:0] width);
    int unsigned     res;
    longint unsigned full;
    longint unsigned scaled;
    longint unsigned seg;
    longint unsigned frac;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned blend;
    res = width;
    if (res < 1) res = 1;
    if (res > MaxPwmBits) res = MaxPwmBits;
    full = (64'd1 << res) - 64'd1;
    // zero or negative level: dark
    if (lvl == '0 || lvl[LevelW-1]) return '0;
    // one or above: saturate at full scale
    if (lvl >= (1 << FracBits)) return full[DutyW-1:0];
    scaled = lvl * SegCount;
    seg    = scaled >> FracBits;
    frac   = scaled & ((64'd1 << FracBits) - 64'd1);
    lo     = CalCurve[seg];
    hi     = CalCurve[seg + 1];
    blend  = (lo << FracBits) + (hi - lo) * frac;
    return DutyW'((blend * full) >> (CalFracBits + FracBits));
  endfunction

  // Random level: mostly inside the curve, some right at segment edges,
  // the rest negative, zero or saturated.
  function automatic logic [LevelW-1:0] pick_level();
    int unsigned sel;
    int unsigned edge_pos;
    sel = $urandom_range(0, 99);
    if (sel < 62) begin
      return LevelW'($urandom_range(1, (1 << FracBits) - 1));
    end else if (sel < 78) begin
      edge_pos = ($urandom_range(1, SegCount - 1) << FracBits) / SegCount;
      return LevelW'(edge_pos + $urandom_range(0, 4) - 2);
    end else if (sel < 88) begin
      return LevelW'((1 << (LevelW - 1)) | $urandom_range(0, (1 << (LevelW - 1)) - 1));
    end else if (sel < 90) begin
      return '0;
    end else begin
      return LevelW'($urandom_range(1 << FracBits, (1 << (LevelW - 1)) - 1));
    end
  endfunction

  // Driver: predict at acceptance, then refill the channel from level_q
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      lvl_ch.valid <= 1'b0;
      lvl_ch.level <= '0;
      src_gap      <= 0;
    end else begin
      if (lvl_ch.valid && lvl_ch.ready) begin
        duty_exp_q.push_back('{level: lvl_ch.level,
                               duty:  duty_for_level(lvl_ch.level, width_now)});
      end
      // channel free: hold the current item otherwise
      if (!lvl_ch.valid || lvl_ch.ready) begin
        if (src_gap != 0) begin
          src_gap      <= src_gap - 1;
          lvl_ch.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
          src_gap      <= $urandom_range(0, 18);
          lvl_ch.valid <= 1'b0;
        end else if (level_q.size() != 0) begin
          lvl_ch.valid <= 1'b1;
          lvl_ch.level <= level_q.pop_front();
        end else begin
          lvl_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted duty item, then decide on ready
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      duty_ch.ready <= 1'b0;
      sink_gap      <= 0;
      hold_cnt      <= 0;
      hold_ack      <= 0;
    end else begin
      if (duty_ch.valid && duty_ch.ready) begin
        if (duty_exp_q.size() == 0) begin
          $display("%0t: duty item with nothing expected: expected none, actual %0d",
                   $time, duty_ch.duty);
          n_mismatch++;
        end else if (duty_ch.duty !== duty_exp_q[0].duty) begin
          $display("%0t: duty mismatch for level %0d: expected %0d, actual %0d",
                   $time, $signed(duty_exp_q[0].level), duty_exp_q[0].duty, duty_ch.duty);
          n_mismatch++;
          void'(duty_exp_q.pop_front());
        end else begin
          void'(duty_exp_q.pop_front());
        end
      end
      // a long hold-off lets every stage fill so the input has to stall
      if (hold_cnt != 0) begin
        hold_cnt      <= hold_cnt - 1;
        duty_ch.ready <= 1'b0;
      end else if (hold_req != hold_ack) begin
        hold_ack      <= hold_ack + 1;
        hold_cnt      <= HoldCycles - 1;
        duty_ch.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap      <= sink_gap - 1;
        duty_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        sink_gap      <= $urandom_range(0, 18);
        duty_ch.ready <= 1'b0;
      end else begin
        duty_ch.ready <= 1'b1;
      end
    end
  end

  // Wait until every level is offered, accepted and its duty has come back
  task automatic wait_drained();
    while (level_q.size() != 0 || duty_exp_q.size() != 0 || lvl_ch.valid)
      @(negedge clk_i);
  endtask

  // Write pwm_bits; only called with nothing in flight
  task automatic write_width(input logic [PwmBitsW-1:0] width);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= width;
    width_now    = width;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Queue a batch of random levels, then pause the sender until all are back
  task automatic run_batch(input int count);
    for (int i = 0; i < count; i++) level_q.push_back(pick_level());
    wait_drained();
  endtask

  // Sequencer
  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    lvl_ch.valid = 1'b0;
    lvl_ch.level = '0;
    duty_ch.ready = 1'b0;
    width_now    = PwmBitsReset;
    idle_on      = 1'b1;
    n_mismatch   = 0;
    hold_req     = 0;
    repeat (RstCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed levels at the reset resolution: sign and saturation edges,
    // segment edges, alternating bit patterns.
    level_q.push_back(18'd0);
    level_q.push_back(18'd1);
    level_q.push_back(18'd65535);
    level_q.push_back(18'd65536);
    level_q.push_back(18'd65537);
    level_q.push_back(18'h1FFFF);
    level_q.push_back(18'h3FFFF);
    level_q.push_back(18'h20000);
    level_q.push_back(18'd6553);
    level_q.push_back(18'd6554);
    level_q.push_back(18'd13107);
    level_q.push_back(18'd32768);
    level_q.push_back(18'd58982);
    level_q.push_back(18'd58983);
    level_q.push_back(18'd39321);
    level_q.push_back(18'h0AAAA);
    level_q.push_back(18'h05555);
    level_q.push_back(18'h15555);
    level_q.push_back(18'h2AAAA);
    wait_drained();

    for (int p = 0; p < PhaseCount; p++) begin
      write_width(WidthPlan[p]);
      // a quiet phase in the middle and a quiet tail
      idle_on = (p != 2) && (p != PhaseCount - 1);
      if (p == 1) hold_req++;
      if (p == 4) begin
        // sender pause mid-phase, same resolution on both halves
        run_batch(PhaseItems / 2);
        run_batch(PhaseItems / 2);
      end else begin
        run_batch(PhaseItems);
      end
    end

    // let any stray duty item show up before judging
    repeat (DrainCycles) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("%0t: timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule
